FILE: src/csem_pkg.sv
// Shared types and constants for the counting semaphore bank.
package csem_pkg;

  localparam int SEM_COUNT_DEF = 16;
  localparam logic signed [15:0] COUNT_MAX = 16'sh7fff;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_WAIT  = 2'd1,
    CMD_POST  = 2'd2,
    CMD_FREE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_INDEX   = 3'd1,
    ST_WOULD_BLOCK = 3'd2,
    ST_NONE_FREE   = 3'd3,
    ST_SATURATED   = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [7:0]         sem_index;
    logic signed [15:0] initial_count;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         granted_index;
    logic signed [15:0] count_after;
    logic               wake;
  } out_item_t;

  // Result of one pass through the shared count unit.
  typedef struct packed {
    status_e            status;
    logic signed [15:0] count;
    logic               wake;
    logic               wr;
  } alu_res_t;

endpackage

FILE: src/csem_mem.sv
// Count storage: one write port, one registered read port.
module csem_mem import csem_pkg::*; #(
  parameter int DEPTH = SEM_COUNT_DEF,
  parameter int IW    = 4
) (
  input  logic                     clk,
  input  logic [IW-1:0]            rd_addr,
  output logic signed [15:0]       rd_data,
  input  logic                     wr_en,
  input  logic [IW-1:0]            wr_addr,
  input  logic signed [15:0]       wr_data
);

  logic signed [15:0] mem [DEPTH];
  logic signed [15:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/csem_alu.sv
// Shared count unit: one incrementer/decrementer with its bound compare.
module csem_alu import csem_pkg::*; (
  input  logic               is_post,
  input  logic signed [15:0] cnt,
  output alu_res_t           res
);

  logic signed [15:0] sum;
  logic               blocked;

  assign sum = cnt + (is_post ? 16'sd1 : -16'sd1);

  // post stops at the top, wait stops at zero or below
  assign blocked = is_post ? (cnt == COUNT_MAX) : (cnt[15] || (cnt == 16'sd0));

  always_comb begin
    res = '0;
    if (blocked) begin
      res.status = is_post ? ST_SATURATED : ST_WOULD_BLOCK;
      res.count  = cnt;
      res.wake   = 1'b0;
      res.wr     = 1'b0;
    end else begin
      res.status = ST_OK;
      res.count  = sum;
      res.wake   = is_post;
      res.wr     = 1'b1;
    end
  end

endmodule

FILE: src/counting_semaphore_table_core.sv
// Top level of the counting semaphore bank: sequencer, allocation bits, result register.
//
//  channel  | ports                     | handshake
//  ---------+---------------------------+------------------------------------
//  input    | start, busy, in_data      | beat taken when start && !busy
//  result   | out_valid, out_data       | one-cycle strobe, never held off
//
// Bad index and free finish straight from idle; wait and post go through S_EXEC (registered count
// read, then one pass through the shared inc/dec unit and write back).
// Allocate scans the allocation bits one entry a cycle, from entry 0 to a free one or the last.
// For wait, post and allocate, busy is high from the cycle after acceptance until the result strobe.
// Reset clears all allocation bits at once; counts of free entries are never read.
// Results cannot be stalled.
module counting_semaphore_table_core import csem_pkg::*; #(
  parameter int SEM_COUNT = SEM_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int IW = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
  localparam logic [8:0] SEM_LIMIT = 9'(SEM_COUNT);
  localparam logic [IW-1:0] LAST_IDX = IW'(SEM_COUNT - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } state_e;

  state_e             state_r, state_nxt;
  logic [SEM_COUNT-1:0] in_use_r, in_use_nxt;
  logic [IW-1:0]      scan_r, scan_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic               post_r, post_nxt;
  logic signed [15:0] init_r, init_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic               accept;
  logic               in_range;
  logic [IW-1:0]      in_idx;
  logic               idx_ok;
  logic [IW-1:0]      rd_addr;
  logic signed [15:0] rd_data;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic signed [15:0] wr_data;
  alu_res_t           alu_res;

  assign accept   = start && (state_r == S_IDLE);
  assign in_range = {1'b0, in_data.sem_index} < SEM_LIMIT;
  assign in_idx   = in_data.sem_index[IW-1:0];
  assign idx_ok   = in_range && in_use_r[in_idx];
  assign rd_addr  = (state_r == S_IDLE) ? in_idx : idx_r;

  csem_mem #(
    .DEPTH (SEM_COUNT),
    .IW    (IW)
  ) u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  csem_alu u_alu (
    .is_post (post_r),
    .cnt     (rd_data),
    .res     (alu_res)
  );

  always_comb begin
    state_nxt     = state_r;
    in_use_nxt    = in_use_r;
    scan_nxt      = scan_r;
    idx_nxt       = idx_r;
    post_nxt      = post_r;
    init_nxt      = init_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = alu_res.count;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt  = in_idx;
          post_nxt = (in_data.command == CMD_POST);
          init_nxt = in_data.initial_count;
          if (in_data.command == CMD_ALLOC) begin
            scan_nxt  = '0;
            state_nxt = S_SCAN;
          end else if (!idx_ok) begin
            out_valid_nxt              = 1'b1;
            out_data_nxt.status        = ST_BAD_INDEX;
            out_data_nxt.granted_index = in_data.sem_index;
            out_data_nxt.count_after   = '0;
            out_data_nxt.wake          = 1'b0;
          end else if (in_data.command == CMD_FREE) begin
            // count of a free entry is never read, so no clear is needed
            in_use_nxt[in_idx]         = 1'b0;
            out_valid_nxt              = 1'b1;
            out_data_nxt.status        = ST_OK;
            out_data_nxt.granted_index = in_data.sem_index;
            out_data_nxt.count_after   = '0;
            out_data_nxt.wake          = 1'b0;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end

      S_SCAN: begin
        if (!in_use_r[scan_r]) begin
          in_use_nxt[scan_r]         = 1'b1;
          wr_en                      = 1'b1;
          wr_addr                    = scan_r;
          wr_data                    = init_r;
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = ST_OK;
          out_data_nxt.granted_index = 8'(scan_r);
          out_data_nxt.count_after   = init_r;
          out_data_nxt.wake          = 1'b0;
          state_nxt                  = S_IDLE;
        end else if (scan_r == LAST_IDX) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = ST_NONE_FREE;
          out_data_nxt.granted_index = '0;
          out_data_nxt.count_after   = '0;
          out_data_nxt.wake          = 1'b0;
          state_nxt                  = S_IDLE;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      S_EXEC: begin
        wr_en                      = alu_res.wr;
        out_valid_nxt              = 1'b1;
        out_data_nxt.status        = alu_res.status;
        out_data_nxt.granted_index = 8'(idx_r);
        out_data_nxt.count_after   = alu_res.count;
        out_data_nxt.wake          = alu_res.wake;
        state_nxt                  = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_use_r    <= in_use_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_r     <= scan_nxt;
    idx_r      <= idx_nxt;
    post_r     <= post_nxt;
    init_r     <= init_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: dv/tb_counting_semaphore_table_core.sv
// Self-checking testbench for the counting semaphore bank: directed and random requests.
module tb_counting_semaphore_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  import csem_pkg::*;

  localparam int SEM_N      = SEM_COUNT_DEF;
  localparam int RAND_BEATS = 130;
  localparam int CYCLE_CAP  = 400000;

  typedef struct {
    in_item_t req;
    int       idle_pct;
  } pending_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  req_bus = '0;
  logic      out_valid;
  out_item_t out_data;

  pending_t  pend_q[$];
  out_item_t grant_q[$];

  // predictor copy of the bank
  logic               sem_used[SEM_N];
  logic signed [15:0] sem_cnt[SEM_N];

  logic beat_taken = 1'b0;
  int   err_cnt = 0;
  int   req_cnt = 0;
  int   res_cnt = 0;
  int   cycles = 0;
  int   status_seen[5] = '{default: 0};

  counting_semaphore_table_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (req_bus),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic out_item_t sem_bank_apply(in_item_t req);
    out_item_t r;
    int        slot;
    logic      found;
    r = '0;
    r.granted_index = req.sem_index;
    slot = int'(req.sem_index);
    found = 1'b0;
    if (cmd_e'(req.command) == CMD_ALLOC) begin
      r.status = ST_NONE_FREE;
      r.granted_index = '0;
      for (int i = 0; i < SEM_N; i++) begin
        if (!found && !sem_used[i]) begin
          found = 1'b1;
          sem_used[i] = 1'b1;
          sem_cnt[i] = req.initial_count;
          r.status = ST_OK;
          r.granted_index = i[7:0];
          r.count_after = req.initial_count;
        end
      end
    end else if (slot >= SEM_N || !sem_used[slot]) begin
      r.status = ST_BAD_INDEX;
    end else begin
      case (cmd_e'(req.command))
        CMD_WAIT: begin
          if (sem_cnt[slot] <= 0) begin
            r.status = ST_WOULD_BLOCK;
          end else begin
            sem_cnt[slot] = sem_cnt[slot] - 16'sd1;
            r.status = ST_OK;
          end
          r.count_after = sem_cnt[slot];
        end
        CMD_POST: begin
          if (sem_cnt[slot] == COUNT_MAX) begin
            r.status = ST_SATURATED;
          end else begin
            sem_cnt[slot] = sem_cnt[slot] + 16'sd1;
            r.status = ST_OK;
            r.wake = 1'b1;
          end
          r.count_after = sem_cnt[slot];
        end
        default: begin
          sem_used[slot] = 1'b0;
          sem_cnt[slot] = '0;
          r.status = ST_OK;
        end
      endcase
    end
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  // results first, then the beat taken at this edge
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n && out_valid) begin
      if (grant_q.size() == 0) begin
        $display("%0t ns: unexpected result, status %0d index %0d count %0d wake %0d",
                 $time, out_data.status, out_data.granted_index,
                 out_data.count_after, out_data.wake);
        err_cnt++;
      end else begin
        want = grant_q.pop_front();
        res_cnt++;
        if (want.status < 5) status_seen[want.status]++;
        check_field("status", want.status, out_data.status);
        check_field("granted_index", want.granted_index, out_data.granted_index);
        check_field("count_after", want.count_after, out_data.count_after);
        check_field("wake", want.wake, out_data.wake);
      end
    end
    if (rst_n && start && !busy) begin
      grant_q.push_back(sem_bank_apply(req_bus));
      req_cnt++;
      beat_taken <= 1'b1;
    end else begin
      beat_taken <= 1'b0;
    end
  end

  always @(negedge clk) begin : driver
    pending_t nxt;
    if (rst_n && (!start || beat_taken)) begin
      if (pend_q.size() != 0 && $urandom_range(0, 99) >= pend_q[0].idle_pct) begin
        nxt = pend_q.pop_front();
        req_bus <= nxt.req;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, grant_q.size());
      $display("tb_counting_semaphore_table_core: FAIL");
      $finish;
    end
  end

  task automatic queue_req(cmd_e c, int idx, int cnt, int idle_pct);
    pending_t p;
    p.req.command = c;
    p.req.sem_index = idx[7:0];
    p.req.initial_count = cnt[15:0];
    p.idle_pct = idle_pct;
    pend_q.push_back(p);
  endtask

  function automatic in_item_t rand_req();
    in_item_t req;
    int       r;
    int       v;
    r = $urandom_range(0, 99);
    if (r < 25)      req.command = CMD_ALLOC;
    else if (r < 55) req.command = CMD_WAIT;
    else if (r < 85) req.command = CMD_POST;
    else             req.command = CMD_FREE;
    // mostly live entries, some out of range
    r = $urandom_range(0, 99);
    if (r < 85)      req.sem_index = 8'($urandom_range(0, SEM_N - 1));
    else if (r < 95) req.sem_index = 8'($urandom_range(SEM_N, 255));
    else             req.sem_index = 8'($urandom_range(0, 255));
    // small counts hit the zero boundary, a few sit near either end
    r = $urandom_range(0, 99);
    if (r < 50)      v = int'($urandom_range(0, 6)) - 2;
    else if (r < 70) v = 32767 - int'($urandom_range(0, 3));
    else if (r < 80) v = -32768 + int'($urandom_range(0, 3));
    else             v = int'($urandom);
    req.initial_count = v[15:0];
    return req;
  endfunction

  initial begin : stimulus
    int       idle_by_phase[4];
    pending_t p;
    idle_by_phase = '{0, 48, 0, 35};
    for (int i = 0; i < SEM_N; i++) begin
      sem_used[i] = 1'b0;
      sem_cnt[i] = '0;
    end

    // directed: unallocated index, count extremes, range errors, reuse, full bank
    queue_req(CMD_WAIT, 0, 0, 0);
    queue_req(CMD_ALLOC, 200, 32767, 0);
    queue_req(CMD_POST, 0, 0, 0);
    queue_req(CMD_WAIT, 0, -1, 0);
    queue_req(CMD_ALLOC, 255, -32768, 0);
    queue_req(CMD_WAIT, 1, 0, 0);
    queue_req(CMD_POST, 1, 0, 0);
    queue_req(CMD_ALLOC, 0, 0, 0);
    queue_req(CMD_WAIT, 2, 0, 0);
    queue_req(CMD_POST, 255, 0, 0);
    queue_req(CMD_FREE, SEM_N, 0, 0);
    queue_req(CMD_FREE, 0, 0, 0);
    queue_req(CMD_ALLOC, 0, 1, 0);
    for (int i = 3; i <= SEM_N; i++) queue_req(CMD_ALLOC, 0, i, 0);

    for (int ph = 0; ph < 4; ph++) begin
      for (int i = 0; i < RAND_BEATS; i++) begin
        p.req = rand_req();
        p.idle_pct = idle_by_phase[ph];
        pend_q.push_back(p);
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pend_q.size() != 0 || start || grant_q.size() != 0) @(posedge clk);
    repeat (SEM_N + 8) @(posedge clk);
    if (grant_q.size() != 0) begin
      $display("%0d expected results never arrived", grant_q.size());
      err_cnt++;
    end

    $display("Sent %0d requests, checked %0d results (ok %0d, bad index %0d)",
             req_cnt, res_cnt, status_seen[ST_OK], status_seen[ST_BAD_INDEX]);
    $display("Would-block %0d, bank full %0d, saturated %0d, mismatches %0d",
             status_seen[ST_WOULD_BLOCK], status_seen[ST_NONE_FREE],
             status_seen[ST_SATURATED], err_cnt);
    if (err_cnt == 0) begin
      $display("tb_counting_semaphore_table_core: PASS");
    end else begin
      $display("tb_counting_semaphore_table_core: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/csem_pkg.sv
src/csem_mem.sv
src/csem_alu.sv
src/counting_semaphore_table_core.sv
dv/tb_counting_semaphore_table_core.sv
